### design/sras_pkg.sv
// ============================================================================
// sras_pkg
// Shared types and constants of the serial register access slave.
// ============================================================================
package sras_pkg;

    localparam int ADDR_BITS        = 5;
    localparam int BYTE_W           = 8;
    localparam int VALUE_W          = 16;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_INDEX_W      = 3;
    localparam int NUM_REGS_DEFAULT = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED_MAP   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED_MASK = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE_MASK     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_CODE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEEK_CODE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONT_CODE     = 3'd5;

    localparam logic [CFG_DATA_W-1:0] ENABLED_MAP_RST   = 32'h0000_0000;
    localparam logic [BYTE_W-1:0]     RESERVED_MASK_RST = 8'h80;
    localparam logic [BYTE_W-1:0]     MODE_MASK_RST     = 8'h60;
    localparam logic [BYTE_W-1:0]     WRITE_CODE_RST    = 8'h00;
    localparam logic [BYTE_W-1:0]     PEEK_CODE_RST     = 8'h40;
    localparam logic [BYTE_W-1:0]     CONT_CODE_RST     = 8'h60;

    localparam logic [1:0] REQ_HOST     = 2'd0;
    localparam logic [1:0] REQ_LOCAL_WR = 2'd1;
    localparam logic [1:0] REQ_TOUCH    = 2'd2;

    localparam logic [1:0] BEAT_ADDR = 2'd0;
    localparam logic [1:0] BEAT_LOW  = 2'd1;
    localparam logic [1:0] BEAT_HIGH = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2
    } phase_t;

    typedef struct packed {
        logic                 send;
        logic                 chg_valid;
        logic [ADDR_BITS-1:0] chg_addr;
        logic                 status;
        logic [ADDR_BITS-1:0] addr;
    } job_t;

endpackage

### design/serial_register_access_slave.sv
// ============================================================================
// serial_register_access_slave
// Byte-stream slave that gives a host read, write and monitor access to a
// bank of sixteen-bit registers held in a synchronous memory.
// ============================================================================
//  Channel  | Handshake          | Payload
//  ---------+--------------------+---------------------------------------------
//  cfg      | cfg_we             | cfg_index, cfg_wdata
//  in       | in_valid, in_ready | req_type, data_byte, reg_addr, reg_value
//  out      | out_valid,out_ready| tx_valid, tx_byte, changed_valid,
//           |                    | changed_addr, status, last
//
// An input word is taken every cycle while no three-word send is under way and
// the output takes each word; its first result word goes through a_job_reg and
// then b_job_reg, the output register. A peek or a monitored touch of an
// enabled register gives three result words; every other input word gives one.
// The register memory is read or written at most once per accepted word, at accept.
// One accepted word waits behind a stalled output; reset needs no clearing pass.
module serial_register_access_slave
    import sras_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             req_type,
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic [ADDR_BITS-1:0]   reg_addr,
    input  logic [VALUE_W-1:0]     reg_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   tx_valid,
    output logic [BYTE_W-1:0]      tx_byte,
    output logic                   changed_valid,
    output logic [ADDR_BITS-1:0]   changed_addr,
    output logic                   status,
    output logic                   last
);

    localparam int IDX_W = $clog2(NUM_REGS);
    localparam logic [ADDR_BITS:0] NUM_REGS_CMP = (ADDR_BITS+1)'(NUM_REGS);

    logic [CFG_DATA_W-1:0] enabled_map_reg;
    logic [BYTE_W-1:0]     reserved_mask_reg;
    logic [BYTE_W-1:0]     mode_mask_reg;
    logic [BYTE_W-1:0]     write_code_reg;
    logic [BYTE_W-1:0]     peek_code_reg;
    logic [BYTE_W-1:0]     cont_code_reg;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [ADDR_BITS-1:0]  pending_addr_reg;
    logic [ADDR_BITS-1:0]  pending_addr_next;
    logic [BYTE_W-1:0]     pending_low_reg;
    logic [BYTE_W-1:0]     pending_low_next;
    logic [NUM_REGS-1:0]   monitor_reg;
    logic [NUM_REGS-1:0]   monitor_next;

    logic [VALUE_W-1:0]    reg_mem [NUM_REGS];
    logic [VALUE_W-1:0]    rd_data_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [VALUE_W-1:0]    mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;

    logic [ADDR_BITS-1:0]  hdr_addr;
    logic [BYTE_W-1:0]     hdr_mode;
    logic                  hdr_in_range;
    logic                  loc_in_range;
    logic                  pend_in_range;
    logic                  hdr_enabled;
    logic                  loc_enabled;
    logic                  pend_enabled;
    logic                  loc_monitored;
    job_t                  dec_job;

    logic                  in_accept;
    logic                  a_valid_reg;
    job_t                  a_job_reg;
    logic                  a_move;
    logic                  b_valid_reg;
    job_t                  b_job_reg;
    logic [1:0]            b_beat_reg;
    logic [VALUE_W-1:0]    b_data_reg;
    logic                  b_last;
    logic                  b_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_map_reg   <= ENABLED_MAP_RST;
            reserved_mask_reg <= RESERVED_MASK_RST;
            mode_mask_reg     <= MODE_MASK_RST;
            write_code_reg    <= WRITE_CODE_RST;
            peek_code_reg     <= PEEK_CODE_RST;
            cont_code_reg     <= CONT_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLED_MAP:   enabled_map_reg   <= cfg_wdata;
                CFG_RESERVED_MASK: reserved_mask_reg <= cfg_wdata[BYTE_W-1:0];
                CFG_MODE_MASK:     mode_mask_reg     <= cfg_wdata[BYTE_W-1:0];
                CFG_WRITE_CODE:    write_code_reg    <= cfg_wdata[BYTE_W-1:0];
                CFG_PEEK_CODE:     peek_code_reg     <= cfg_wdata[BYTE_W-1:0];
                CFG_CONT_CODE:     cont_code_reg     <= cfg_wdata[BYTE_W-1:0];
                default:           ;
            endcase
        end
    end

    assign hdr_addr      = data_byte[ADDR_BITS-1:0];
    assign hdr_mode      = data_byte & mode_mask_reg;
    assign hdr_in_range  = {1'b0, hdr_addr} < NUM_REGS_CMP;
    assign loc_in_range  = {1'b0, reg_addr} < NUM_REGS_CMP;
    assign pend_in_range = {1'b0, pending_addr_reg} < NUM_REGS_CMP;
    assign hdr_enabled   = hdr_in_range && enabled_map_reg[hdr_addr];
    assign loc_enabled   = loc_in_range && enabled_map_reg[reg_addr];
    assign pend_enabled  = pend_in_range && enabled_map_reg[pending_addr_reg];
    assign loc_monitored = loc_in_range && monitor_reg[reg_addr[IDX_W-1:0]];

    always_comb
    begin
        phase_next        = phase_reg;
        pending_addr_next = pending_addr_reg;
        pending_low_next  = pending_low_reg;
        monitor_next      = monitor_reg;
        mem_we            = 1'b0;
        mem_waddr         = reg_addr[IDX_W-1:0];
        mem_wdata         = reg_value;
        mem_re            = 1'b0;
        mem_raddr         = reg_addr[IDX_W-1:0];
        dec_job           = '0;
        dec_job.addr      = reg_addr;
        case (req_type)
            REQ_HOST:
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        dec_job.addr = hdr_addr;
                        mem_raddr    = hdr_addr[IDX_W-1:0];
                        if ((data_byte & reserved_mask_reg) != '0)
                        begin
                            dec_job.status = 1'b1;
                        end
                        else if (hdr_mode == write_code_reg)
                        begin
                            pending_addr_next = hdr_addr;
                            phase_next        = PH_LOW;
                        end
                        else if (hdr_mode == peek_code_reg)
                        begin
                            dec_job.send = hdr_enabled;
                            mem_re       = hdr_enabled;
                        end
                        else if (hdr_mode == cont_code_reg)
                        begin
                            if (hdr_in_range)
                            begin
                                monitor_next[hdr_addr[IDX_W-1:0]] =
                                    ~monitor_reg[hdr_addr[IDX_W-1:0]];
                            end
                        end
                        else
                        begin
                            dec_job.status = 1'b1;
                        end
                    end
                    PH_LOW:
                    begin
                        pending_low_next = data_byte;
                        phase_next       = PH_HIGH;
                    end
                    PH_HIGH:
                    begin
                        phase_next = PH_IDLE;
                        mem_waddr  = pending_addr_reg[IDX_W-1:0];
                        mem_wdata  = {data_byte, pending_low_reg};
                        if (pend_enabled)
                        begin
                            mem_we            = 1'b1;
                            dec_job.chg_valid = 1'b1;
                            dec_job.chg_addr  = pending_addr_reg;
                        end
                        else
                        begin
                            dec_job.status = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next     = PH_IDLE;
                        dec_job.status = 1'b1;
                    end
                endcase
            end
            REQ_LOCAL_WR:
            begin
                if (loc_in_range)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    dec_job.status = 1'b1;
                end
            end
            REQ_TOUCH:
            begin
                if (loc_monitored)
                begin
                    dec_job.send = loc_enabled;
                    mem_re       = loc_enabled;
                end
                else
                begin
                    dec_job.status = 1'b1;
                end
            end
            default:
            begin
                dec_job.status = 1'b1;
            end
        endcase
    end

    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            pending_addr_reg <= '0;
            pending_low_reg  <= '0;
            monitor_reg      <= '0;
        end
        else if (in_accept)
        begin
            phase_reg        <= phase_next;
            pending_addr_reg <= pending_addr_next;
            pending_low_reg  <= pending_low_next;
            monitor_reg      <= monitor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && mem_we)
        begin
            reg_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept && mem_re)
        begin
            rd_data_reg <= reg_mem[mem_raddr];
        end
    end

    assign b_last   = !b_job_reg.send || (b_beat_reg == BEAT_HIGH);
    assign b_free   = !b_valid_reg || (out_ready && b_last);
    assign a_move   = a_valid_reg && b_free;
    assign in_ready = !a_valid_reg || a_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            b_beat_reg  <= BEAT_ADDR;
        end
        else
        begin
            if (in_accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_move)
            begin
                b_valid_reg <= 1'b1;
                b_beat_reg  <= BEAT_ADDR;
            end
            else if (b_valid_reg && out_ready)
            begin
                if (b_last)
                begin
                    b_valid_reg <= 1'b0;
                end
                else
                begin
                    b_beat_reg <= b_beat_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_job_reg <= dec_job;
        end
        if (a_move)
        begin
            b_job_reg  <= a_job_reg;
            b_data_reg <= rd_data_reg;
        end
    end

    always_comb
    begin
        case (b_beat_reg)
            BEAT_ADDR: tx_byte = {{(BYTE_W-ADDR_BITS){1'b0}}, b_job_reg.addr};
            BEAT_LOW:  tx_byte = b_data_reg[BYTE_W-1:0];
            BEAT_HIGH: tx_byte = b_data_reg[VALUE_W-1:BYTE_W];
            default:   tx_byte = '0;
        endcase
        if (!b_job_reg.send)
        begin
            tx_byte = '0;
        end
    end

    assign out_valid     = b_valid_reg;
    assign tx_valid      = b_job_reg.send;
    assign changed_valid = !b_job_reg.send && b_job_reg.chg_valid;
    assign changed_addr  = changed_valid ? b_job_reg.chg_addr : '0;
    assign status        = !b_job_reg.send && b_job_reg.status;
    assign last          = b_last;

endmodule

### design/sras_checker.sv
// ============================================================================
// sras_checker
// Port-level checks of the serial register access slave result stream.
// ============================================================================
module sras_checker
    import sras_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 tx_valid,
    input logic [BYTE_W-1:0]    tx_byte,
    input logic                 changed_valid,
    input logic [ADDR_BITS-1:0] changed_addr,
    input logic                 status,
    input logic                 last
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(tx_valid) &&
        $stable(tx_byte) && $stable(changed_valid) && $stable(changed_addr) &&
        $stable(status) && $stable(last)))
        else $error("Result word changed while stalled.");

    a_send_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && tx_valid && !last) |=> (out_valid && tx_valid))
        else $error("Byte send broke off before its final word.");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (last && !tx_valid && !changed_valid))
        else $error("Error word carries data or is not final.");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && changed_valid) |-> (!tx_valid && last))
        else $error("Change notice mixed with a byte send.");

    a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !tx_valid) |-> (tx_byte == '0))
        else $error("Byte is nonzero on a word without a send.");

endmodule

bind serial_register_access_slave sras_checker u_sras_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tx_valid      (tx_valid),
    .tx_byte       (tx_byte),
    .changed_valid (changed_valid),
    .changed_addr  (changed_addr),
    .status        (status),
    .last          (last)
);
